// File: hdl/mglre_pkg.sv
// Package for the multi-group linear ramp engine.
// Holds the group entry type, the command and sequencer codes and the
// fixed-point helper functions. Depends on nothing.
package mglre_pkg;

  localparam int NCH      = 3;
  localparam int VW       = 32;
  localparam int DURW     = 31;
  localparam int TESTW    = 49;
  localparam int DIVW     = 49;
  localparam int DIV_CNTW = 6;

  localparam logic [VW-1:0] ONE_Q16  = 32'h0001_0000;
  localparam logic [VW-1:0] HALF_Q16 = 32'h0000_8000;
  localparam logic [VW-1:0] SAT_MAX  = 32'h7fff_ffff;
  localparam logic [VW-1:0] SAT_MIN  = 32'h8000_0000;

  localparam int GRP_SCALE = 2;
  localparam int GRP_COLOR = 5;
  localparam int GRP_FADE  = 6;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_SET  = 2'd1,
    OP_ADD  = 2'd2,
    OP_RAMP = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_MUL,
    ST_ACC,
    ST_DIV,
    ST_DIVW,
    ST_FIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic                   active;
    logic [NCH-1:0][VW-1:0] rate;
    logic [NCH-1:0][VW-1:0] goal;
    logic [NCH-1:0][VW-1:0] cur;
  } grp_entry_t;

  // Saturate a wide signed value to 32 bits.
  function automatic logic [VW-1:0] sat_to32(input logic signed [TESTW-1:0] v);
    logic [VW-1:0] r;
    if (v > $signed({{(TESTW-VW){1'b0}}, SAT_MAX})) begin
      r = SAT_MAX;
    end else if (v < $signed({{(TESTW-VW){1'b1}}, SAT_MIN})) begin
      r = SAT_MIN;
    end else begin
      r = v[VW-1:0];
    end
    return r;
  endfunction

  // Contents of a group right after reset.
  function automatic grp_entry_t default_entry(input int unsigned g);
    grp_entry_t e;
    e = '0;
    case (g)
      GRP_SCALE: begin
        e.cur[0] = ONE_Q16;
        e.cur[1] = ONE_Q16;
        e.cur[2] = ONE_Q16;
      end
      GRP_COLOR: begin
        e.cur[0] = HALF_Q16;
        e.cur[2] = ONE_Q16;
      end
      GRP_FADE: begin
        e.cur[0] = ONE_Q16;
      end
      default: begin
      end
    endcase
    return e;
  endfunction

endpackage

// File: hdl/mglre_in_if.sv
// Command channel of the ramp engine: valid/ready handshake plus payload.
// Depends on nothing.
interface mglre_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [2:0]  group;
  logic [31:0] target_a;
  logic [31:0] target_b;
  logic [31:0] target_c;
  logic [30:0] duration;
  logic [30:0] elapsed;

  modport source (output valid, op, group, target_a, target_b, target_c,
                  duration, elapsed, input ready);
  modport sink   (input valid, op, group, target_a, target_b, target_c,
                  duration, elapsed, output ready);
endinterface

// File: hdl/mglre_out_if.sv
// Result channel of the ramp engine: valid/ready handshake plus payload.
// Depends on nothing.
interface mglre_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  out_group;
  logic [31:0] value_a;
  logic [31:0] value_b;
  logic [31:0] value_c;
  logic        ramping;
  logic        last;

  modport source (output valid, out_group, value_a, value_b, value_c,
                  ramping, last, input ready);
  modport sink   (input valid, out_group, value_a, value_b, value_c,
                  ramping, last, output ready);
endinterface

// File: hdl/mglre_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module mglre_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// File: hdl/mglre_div.sv
// Restoring divider, one quotient bit per cycle, for ramp rate setup.
// Depends on mglre_pkg.
module mglre_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [mglre_pkg::DIVW-1:0] dividend,
  input  logic [mglre_pkg::DURW-1:0] divisor,
  output logic                       done,
  output logic [mglre_pkg::DIVW-1:0] quotient
);
  import mglre_pkg::*;

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [DIV_CNTW-1:0] cnt_r, cnt_nxt;
  logic [DIVW-1:0]     q_r, q_nxt;
  logic [DURW-1:0]     rem_r, rem_nxt;
  logic [DURW-1:0]     dvs_r, dvs_nxt;
  logic [DURW:0]       rem_sh;
  logic                ge;

  assign rem_sh = {rem_r, q_r[DIVW-1]};
  assign ge     = rem_sh >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      q_nxt   = {q_r[DIVW-2:0], ge};
      rem_nxt = ge ? DURW'(rem_sh - {1'b0, dvs_r}) : rem_sh[DURW-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNTW'(DIVW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;
endmodule

// File: hdl/multi_group_linear_ramp_engine.sv
// Top level of the multi-group linear ramp engine.
// Depends on mglre_pkg, mglre_in_if, mglre_out_if, mglre_ram and mglre_div.
//
// Commands arrive on in_ch and results leave on out_ch, both valid/ready;
// an item moves when valid and ready are high at a rising edge. Each group
// (three Q16.16 values, goals, rates and a ramp flag) is one word of a
// single-port-read RAM, read, modified and written back by a sequencer.
// A command is taken only while the sequencer is idle; one item is in
// work at a time.
// Set and add pass through the read, load, write-back and emit states.
// Start ramp runs the shared divider once per channel, one quotient bit a
// cycle. With a zero duration it skips the divider.
// A tick visits every group; an idle group is only read, a ramping one
// also passes the multiply and accumulate states (the shared multiplier
// serves the three channels in turn). A tick gives GROUPS items.
// After reset the sequencer sweeps the RAM, writing the default contents
// of one group per cycle; in_ch stays not ready during the sweep.
// A result sits in an output register; when the receiver stalls, the
// sequencer waits before loading the next one, and a new command can be
// accepted while the last result of the previous one still waits.
module multi_group_linear_ramp_engine #(
  parameter int GROUPS = 8
) (
  input logic        clk,
  input logic        rst_n,
  mglre_in_if.sink   in_ch,
  mglre_out_if.source out_ch
);
  import mglre_pkg::*;

  localparam int IDXW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int EW   = $bits(grp_entry_t);
  localparam logic [IDXW-1:0] LAST_GRP = IDXW'(GROUPS - 1);

  state_t                 state_r, state_nxt;
  op_t                    op_r;
  logic [IDXW-1:0]        grp_r;
  logic [2:0]             grp_raw_r;
  logic                   oor_r;
  logic [NCH-1:0][VW-1:0] tgt_r;
  logic [DURW-1:0]        dur_r;
  logic [DURW-1:0]        el_r;
  grp_entry_t             ent_r;
  grp_entry_t             fin_ent;
  logic [1:0]             ch_r;
  logic                   over_r;
  logic signed [TESTW-1:0] test_r [NCH];
  logic [62:0]            prod_r;
  logic                   div_neg_r;

  logic                   out_valid_r;
  logic [2:0]             out_group_r;
  logic [NCH-1:0][VW-1:0] out_val_r;
  logic                   out_ramping_r;
  logic                   out_last_r;

  // Sequencer strobes.
  logic in_ready;
  logic ram_re;
  logic ram_we;
  logic div_start;
  logic emit_go;
  logic in_acc;
  logic in_oor;
  logic last_grp;
  logic last_ch;

  grp_entry_t          ram_rdata;
  logic [EW-1:0]       ram_rdata_w;
  grp_entry_t          ram_wdata;

  logic                div_done;
  logic [DIVW-1:0]     div_q;
  logic [DIVW-1:0]     div_dividend;

  // Channel datapath signals.
  logic [VW-1:0]             rate_c;
  logic                      rate_neg;
  logic [VW-1:0]             rate_mag;
  logic signed [TESTW-1:0]   delta_c;
  logic signed [TESTW-1:0]   test_c;
  logic signed [TESTW-1:0]   goal_c;
  logic                      over_c;
  logic signed [VW:0]        diff_c;
  logic [VW:0]               diff_mag;
  logic [VW-1:0]             rate_q;

  assign in_acc   = in_ch.valid && in_ready;
  assign in_oor   = (int'(in_ch.group) >= GROUPS);
  assign last_grp = (grp_r == LAST_GRP);
  assign last_ch  = (ch_r == 2'(NCH - 1));

  // Strobes, decoded from the state.
  always_comb begin
    in_ready  = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    div_start = 1'b0;
    emit_go   = 1'b0;
    case (state_r)
      ST_CLEAR: ram_we    = 1'b1;
      ST_IDLE:  in_ready  = 1'b1;
      ST_READ:  ram_re    = 1'b1;
      ST_DIV:   div_start = 1'b1;
      ST_FIN:   ram_we    = 1'b1;
      ST_EMIT:  emit_go   = !out_valid_r || out_ch.ready;
      default: begin
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (grp_r == LAST_GRP) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (op_t'(in_ch.op) != OP_TICK && in_oor) ? ST_EMIT : ST_READ;
        end
      end
      ST_READ: state_nxt = ST_LOAD;
      ST_LOAD: begin
        case (op_r)
          OP_TICK: state_nxt = ram_rdata.active ? ST_MUL : ST_EMIT;
          OP_RAMP: state_nxt = (dur_r == '0) ? ST_FIN : ST_DIV;
          default: state_nxt = ST_FIN;
        endcase
      end
      ST_MUL:  state_nxt = ST_ACC;
      ST_ACC:  state_nxt = last_ch ? ST_FIN : ST_MUL;
      ST_DIV:  state_nxt = ST_DIVW;
      ST_DIVW: if (div_done) state_nxt = last_ch ? ST_FIN : ST_DIV;
      ST_FIN:  state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (emit_go) begin
          state_nxt = (op_r == OP_TICK && !last_grp) ? ST_READ : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Tick channel: delta = rate * elapsed >> 16, truncated toward zero.
  assign rate_c   = ent_r.rate[ch_r];
  assign rate_neg = rate_c[VW-1];
  assign rate_mag = rate_neg ? (~rate_c + 1'b1) : rate_c;
  assign delta_c  = rate_neg ? -$signed({2'b00, prod_r[62:16]})
                             :  $signed({2'b00, prod_r[62:16]});
  assign test_c   = $signed({{(TESTW-VW){ent_r.cur[ch_r][VW-1]}}, ent_r.cur[ch_r]})
                    + delta_c;
  assign goal_c   = $signed({{(TESTW-VW){ent_r.goal[ch_r][VW-1]}}, ent_r.goal[ch_r]});
  assign over_c   = (rate_neg && (test_c < goal_c))
                 || (!rate_neg && (rate_c != '0) && (test_c > goal_c));

  // Ramp channel: |goal - value| * 65536 / duration, sign applied after.
  assign diff_c       = $signed({tgt_r[ch_r][VW-1], tgt_r[ch_r]})
                      - $signed({ent_r.cur[ch_r][VW-1], ent_r.cur[ch_r]});
  assign diff_mag     = diff_c[VW] ? $unsigned(~diff_c + 1'b1) : $unsigned(diff_c);
  assign div_dividend = {diff_mag, 16'h0000};

  always_comb begin
    if (div_q[DIVW-1:VW-1] != '0) begin
      rate_q = div_neg_r ? SAT_MIN : SAT_MAX;
    end else begin
      rate_q = div_neg_r ? (~div_q[VW-1:0] + 1'b1) : div_q[VW-1:0];
    end
  end

  // Entry as it is written back.
  always_comb begin
    fin_ent = ent_r;
    for (int c = 0; c < NCH; c++) begin
      case (op_r)
        OP_TICK: fin_ent.cur[c] = over_r ? ent_r.goal[c] : sat_to32(test_r[c]);
        OP_SET:  fin_ent.cur[c] = tgt_r[c];
        OP_ADD:  fin_ent.cur[c] = sat_to32(
                   $signed({{(TESTW-VW){ent_r.cur[c][VW-1]}}, ent_r.cur[c]})
                 + $signed({{(TESTW-VW){tgt_r[c][VW-1]}}, tgt_r[c]}));
        OP_RAMP: begin
          fin_ent.goal[c] = tgt_r[c];
          if (dur_r == '0) begin
            fin_ent.cur[c]  = tgt_r[c];
            fin_ent.rate[c] = '0;
          end
        end
        default: begin
        end
      endcase
    end
    case (op_r)
      OP_TICK: if (over_r) fin_ent.active = 1'b0;
      OP_RAMP: fin_ent.active = (dur_r != '0);
      default: begin
      end
    endcase
  end

  assign ram_wdata = (state_r == ST_CLEAR) ? default_entry(int'(grp_r)) : fin_ent;
  assign ram_rdata = grp_entry_t'(ram_rdata_w);

  mglre_ram #(
    .WIDTH (EW),
    .DEPTH (GROUPS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (grp_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (grp_r),
    .rdata (ram_rdata_w)
  );

  mglre_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (dur_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      grp_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        grp_r <= (grp_r == LAST_GRP) ? '0 : grp_r + 1'b1;
      end else if (in_acc) begin
        grp_r <= (op_t'(in_ch.op) == OP_TICK) ? '0 : IDXW'(in_ch.group);
      end else if (emit_go && op_r == OP_TICK && !last_grp) begin
        grp_r <= grp_r + 1'b1;
      end
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r      <= op_t'(in_ch.op);
      grp_raw_r <= in_ch.group;
      oor_r     <= (op_t'(in_ch.op) != OP_TICK) && in_oor;
      tgt_r     <= {in_ch.target_c, in_ch.target_b, in_ch.target_a};
      dur_r     <= in_ch.duration;
      el_r      <= in_ch.elapsed;
    end
    case (state_r)
      ST_LOAD: begin
        ent_r  <= ram_rdata;
        ch_r   <= '0;
        over_r <= 1'b0;
      end
      ST_MUL: prod_r <= {31'b0, rate_mag} * {32'b0, el_r};
      ST_ACC: begin
        test_r[ch_r] <= test_c;
        over_r       <= over_r | over_c;
        ch_r         <= ch_r + 1'b1;
      end
      ST_DIV: div_neg_r <= diff_c[VW];
      ST_DIVW: begin
        if (div_done) begin
          ent_r.rate[ch_r] <= rate_q;
          ch_r             <= ch_r + 1'b1;
        end
      end
      ST_FIN: ent_r <= fin_ent;
      default: begin
      end
    endcase
    if (emit_go) begin
      out_last_r <= (op_r != OP_TICK) || last_grp;
      if (oor_r) begin
        out_group_r   <= grp_raw_r;
        out_val_r     <= '0;
        out_ramping_r <= 1'b0;
      end else begin
        out_group_r   <= 3'(grp_r);
        out_val_r     <= ent_r.cur;
        out_ramping_r <= ent_r.active;
      end
    end
  end

  assign in_ch.ready      = in_ready;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_group = out_group_r;
  assign out_ch.value_a   = out_val_r[0];
  assign out_ch.value_b   = out_val_r[1];
  assign out_ch.value_c   = out_val_r[2];
  assign out_ch.ramping   = out_ramping_r;
  assign out_ch.last      = out_last_r;

  // The reset sweep never overlaps a pending result.
  a_clear_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !out_valid_r)
    else $error("result pending during RAM clearing sweep");

  // The RAM is never written while a command may be taken.
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !ram_we)
    else $error("RAM write while idle");

  // The divider only finishes while the sequencer waits for it.
  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIVW))
    else $error("divider finished outside its wait state");

  // A new result is loaded only if the previous one has gone or goes now.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit_go |-> (!out_valid_r || out_ch.ready))
    else $error("result register overwritten while stalled");

endmodule
